/* hw/rtl/inverse_square_field_sum_core_assert.svh */
// assertion macros used by the checker file
`ifndef INVERSE_SQUARE_FIELD_SUM_CORE_ASSERT_SVH
`define INVERSE_SQUARE_FIELD_SUM_CORE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define ISFS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ISFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* hw/rtl/isfs_pkg.sv */
// ---------------------------------------------------------------------------
// isfs_pkg
// Shared types and constants of the inverse square field sum core.
// ---------------------------------------------------------------------------
package isfs_pkg;

    localparam int MAX_SOURCES   = 5;
    localparam int SRC_IDX_BITS  = 3;
    localparam int COORD_BITS    = 10;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 24;
    localparam int OUT_BITS      = 20;
    localparam int ACC_BITS      = 22;
    localparam int D2_BITS       = 22;
    localparam int ROOT_BITS     = 19;
    localparam int MAG_BITS      = 16;
    localparam int PROD_BITS     = 26;
    localparam int OPA_BITS      = 38;
    localparam int QUO_BITS      = 34;
    localparam int REM_BITS      = 24;
    localparam int CNT_BITS      = 6;
    localparam int DIV_STEPS     = 34;
    localparam int ROOT_STEPS    = 19;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_SOURCE_COUNT = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SOURCE_A     = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_SOURCE_E     = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_STRENGTH     = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_FORCE_CAP    = 3'd7;

    localparam logic [23:0] STRENGTH_RESET  = 24'd1000000;
    localparam logic [15:0] FORCE_CAP_RESET = 16'd5120;

    typedef struct packed {
        logic [COORD_BITS-1:0] point_y;
        logic [COORD_BITS-1:0] point_x;
    } isfs_in_t;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] end_y;
        logic signed [OUT_BITS-1:0] end_x;
    } isfs_out_t;

    typedef enum logic {
        OP_DIV,
        OP_SQRT
    } unit_op_t;

    typedef struct packed {
        logic     start;
        unit_op_t op;
    } unit_req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SELECT,
        ST_DIST,
        ST_MAG,
        ST_MAG_WAIT,
        ST_ROOT,
        ST_ROOT_WAIT,
        ST_PROD,
        ST_COMP,
        ST_COMP_WAIT,
        ST_FINISH
    } seq_state_t;

endpackage

/* hw/rtl/isfs_unit.sv */
// ---------------------------------------------------------------------------
// isfs_unit
// Shared restoring divide / square root unit, one result bit per cycle.
// ---------------------------------------------------------------------------
module isfs_unit
    import isfs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  unit_req_t           req,
    input  logic [OPA_BITS-1:0] opa,
    input  logic [D2_BITS-1:0]  opb,
    output logic                done,
    output logic [QUO_BITS-1:0] result
);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    unit_op_t            op_reg;
    logic [OPA_BITS-1:0] rad_reg;
    logic [REM_BITS-1:0] rem_reg;
    logic [QUO_BITS-1:0] quo_reg;
    logic [D2_BITS-1:0]  dvs_reg;
    logic [CNT_BITS-1:0] cnt_reg;

    logic [REM_BITS+1:0] shifted;
    logic [REM_BITS+1:0] trial;
    logic [REM_BITS+1:0] diff;
    logic                take;

    // one step of the shift-subtract recurrence
    always_comb
    begin
        if (op_reg == OP_SQRT)
        begin
            shifted = {rem_reg, rad_reg[OPA_BITS-1 -: 2]};
            trial   = {quo_reg[REM_BITS-1:0], 2'b01};
        end
        else
        begin
            shifted = {1'b0, rem_reg, rad_reg[OPA_BITS-1]};
            trial   = {{(REM_BITS+2-D2_BITS){1'b0}}, dvs_reg};
        end
        take = (shifted >= trial);
        diff = shifted - trial;
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            busy_next = 1'b1;
        end
        else if (busy_reg && cnt_reg == CNT_BITS'(1))
        begin
            busy_next = 1'b0;
            done_next = 1'b1;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // operand and partial result registers
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            op_reg  <= req.op;
            rad_reg <= opa;
            dvs_reg <= opb;
            rem_reg <= '0;
            quo_reg <= '0;
            cnt_reg <= (req.op == OP_SQRT) ? CNT_BITS'(ROOT_STEPS) : CNT_BITS'(DIV_STEPS);
        end
        else if (busy_reg)
        begin
            rem_reg <= take ? diff[REM_BITS-1:0] : shifted[REM_BITS-1:0];
            quo_reg <= {quo_reg[QUO_BITS-2:0], take};
            rad_reg <= (op_reg == OP_SQRT) ? {rad_reg[OPA_BITS-3:0], 2'b00}
                                           : {rad_reg[OPA_BITS-2:0], 1'b0};
            cnt_reg <= cnt_reg - CNT_BITS'(1);
        end
    end

    assign done   = done_reg;
    assign result = quo_reg;

endmodule

/* hw/rtl/inverse_square_field_sum_core.sv */
// Each active source takes a magnitude divide, a root and two component
// divides on the shared bit-serial divide / root unit; a source on the point is skipped.
// Throughput: one request at a time; the next is taken once the sequencer
// is idle, while a finished result may still wait in the output register.
// Reset: asynchronous active low, clears control and loads register defaults.
// ---------------------------------------------------------------------------
// inverse_square_field_sum_core
// Sums clamped inverse square forces of up to five sources at a grid point.
// ---------------------------------------------------------------------------
module inverse_square_field_sum_core
    import isfs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  isfs_in_t                 in_data,
    output logic                     out_valid,
    input  logic                     out_stall,
    output isfs_out_t                out_data,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    seq_state_t state_reg, state_next;

    logic [2:0]                   count_reg;
    logic [2*COORD_BITS-1:0]      src_reg [MAX_SOURCES];
    logic [23:0]                  strength_reg;
    logic [MAG_BITS-1:0]          cap_reg;

    logic [COORD_BITS-1:0]        px_reg, py_reg;
    logic [SRC_IDX_BITS-1:0]      idx_reg, lim_reg;
    logic signed [COORD_BITS:0]   dx_reg, dy_reg;
    logic [D2_BITS-1:0]           d2_reg;
    logic [MAG_BITS-1:0]          mag_reg;
    logic [ROOT_BITS-1:0]         root_reg;
    logic [PROD_BITS-1:0]         prod_reg;
    logic                         axis_reg;
    logic signed [ACC_BITS-1:0]   sumx_reg, sumy_reg;
    logic                         out_valid_reg;
    isfs_out_t                    out_data_reg;

    unit_req_t                    req;
    logic [OPA_BITS-1:0]          opa;
    logic [D2_BITS-1:0]           opb;
    logic                         unit_done;
    logic [QUO_BITS-1:0]          unit_result;

    logic                         in_take;
    logic                         out_free;
    logic [2*COORD_BITS-1:0]      src;
    logic signed [COORD_BITS:0]   dsel;
    logic [COORD_BITS-1:0]        dabs;
    logic signed [ACC_BITS-1:0]   comp;
    logic signed [OUT_BITS-1:0]   satx, saty;

    isfs_unit u_unit (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .opa    (opa),
        .opb    (opb),
        .done   (unit_done),
        .result (unit_result)
    );

    assign in_take  = in_valid && (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign src      = src_reg[idx_reg];
    assign dsel     = axis_reg ? dy_reg : dx_reg;

    // magnitude of the selected axis
    always_comb
    begin
        logic signed [COORD_BITS:0] neg;
        neg  = -dsel;
        dabs = dsel[COORD_BITS] ? neg[COORD_BITS-1:0] : dsel[COORD_BITS-1:0];
    end

    // signed component from the divider quotient
    always_comb
    begin
        logic signed [ACC_BITS-1:0] q;
        q    = $signed({{(ACC_BITS-MAG_BITS-1){1'b0}}, unit_result[MAG_BITS:0]});
        comp = dsel[COORD_BITS] ? -q : q;
    end

    // saturation of the end point to the output range
    function automatic logic signed [OUT_BITS-1:0] sat(input logic signed [ACC_BITS-1:0] v);
        logic signed [ACC_BITS-1:0] hi, lo;
        hi = ACC_BITS'((1 <<< (OUT_BITS-1)) - 1);
        lo = -ACC_BITS'(1 <<< (OUT_BITS-1));
        if (v > hi)
            return hi[OUT_BITS-1:0];
        else if (v < lo)
            return lo[OUT_BITS-1:0];
        else
            return v[OUT_BITS-1:0];
    endfunction

    assign satx = sat(sumx_reg);
    assign saty = sat(sumy_reg);

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_take)
                    state_next = ST_SELECT;
            ST_SELECT:
                state_next = (idx_reg == lim_reg) ? ST_FINISH : ST_DIST;
            ST_DIST:
                state_next = ST_MAG;
            ST_MAG:
                state_next = (d2_reg == '0) ? ST_SELECT : ST_MAG_WAIT;
            ST_MAG_WAIT:
                if (unit_done)
                    state_next = ST_ROOT;
            ST_ROOT:
                state_next = ST_ROOT_WAIT;
            ST_ROOT_WAIT:
                if (unit_done)
                    state_next = ST_PROD;
            ST_PROD:
                state_next = ST_COMP;
            ST_COMP:
                state_next = ST_COMP_WAIT;
            ST_COMP_WAIT:
                if (unit_done)
                    state_next = axis_reg ? ST_SELECT : ST_PROD;
            ST_FINISH:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // unit requests and operands
    always_comb
    begin
        req.start = 1'b0;
        req.op    = OP_DIV;
        opa       = {2'b00, strength_reg, 8'h00, 4'h0};
        opb       = d2_reg;
        case (state_reg)
            ST_MAG:
                req.start = (d2_reg != '0);
            ST_ROOT:
            begin
                req.start = 1'b1;
                req.op    = OP_SQRT;
                opa       = {d2_reg, 16'h0000};
            end
            ST_COMP:
            begin
                req.start = 1'b1;
                opa       = {prod_reg, 8'h00, 4'h0};
                opb       = {{(D2_BITS-ROOT_BITS){1'b0}}, root_reg};
            end
            default:
                req.start = 1'b0;
        endcase
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            strength_reg  <= STRENGTH_RESET;
            cap_reg       <= FORCE_CAP_RESET;
            for (int i = 0; i < MAX_SOURCES; i++)
                src_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_FINISH && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            if (cfg_we)
            begin
                if (cfg_index == REG_SOURCE_COUNT)
                    count_reg <= cfg_data[2:0];
                else if (cfg_index == REG_STRENGTH)
                    strength_reg <= cfg_data;
                else if (cfg_index == REG_FORCE_CAP)
                    cap_reg <= cfg_data[MAG_BITS-1:0];
                else if (cfg_index >= REG_SOURCE_A && cfg_index <= REG_SOURCE_E)
                    src_reg[cfg_index - REG_SOURCE_A] <= cfg_data[2*COORD_BITS-1:0];
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
                if (in_take)
                begin
                    px_reg   <= in_data.point_x;
                    py_reg   <= in_data.point_y;
                    sumx_reg <= $signed({{(ACC_BITS-COORD_BITS-8){1'b0}}, in_data.point_x, 8'h00});
                    sumy_reg <= $signed({{(ACC_BITS-COORD_BITS-8){1'b0}}, in_data.point_y, 8'h00});
                    idx_reg  <= '0;
                    lim_reg  <= (count_reg > 3'(MAX_SOURCES)) ? SRC_IDX_BITS'(MAX_SOURCES)
                                                              : count_reg;
                end
            ST_SELECT:
            begin
                dx_reg <= $signed({1'b0, src[COORD_BITS-1:0]}) - $signed({1'b0, px_reg});
                dy_reg <= $signed({1'b0, src[2*COORD_BITS-1:COORD_BITS]})
                        - $signed({1'b0, py_reg});
            end
            ST_DIST:
                d2_reg <= unsigned'(D2_BITS'(dx_reg) * D2_BITS'(dx_reg))
                        + unsigned'(D2_BITS'(dy_reg) * D2_BITS'(dy_reg));
            ST_MAG:
                if (d2_reg == '0)
                    idx_reg <= idx_reg + SRC_IDX_BITS'(1);
            ST_MAG_WAIT:
                if (unit_done)
                    mag_reg <= (unit_result > QUO_BITS'(cap_reg)) ? cap_reg
                                                                  : unit_result[MAG_BITS-1:0];
            ST_ROOT_WAIT:
                if (unit_done)
                begin
                    root_reg <= unit_result[ROOT_BITS-1:0];
                    axis_reg <= 1'b0;
                end
            ST_PROD:
                prod_reg <= PROD_BITS'(mag_reg) * PROD_BITS'(dabs);
            ST_COMP_WAIT:
                if (unit_done)
                begin
                    if (axis_reg)
                    begin
                        sumy_reg <= sumy_reg + comp;
                        idx_reg  <= idx_reg + SRC_IDX_BITS'(1);
                    end
                    else
                    begin
                        sumx_reg <= sumx_reg + comp;
                    end
                    axis_reg <= !axis_reg;
                end
            ST_FINISH:
                if (out_free)
                begin
                    out_data_reg.end_x <= satx;
                    out_data_reg.end_y <= saty;
                end
            default:
                idx_reg <= idx_reg;
        endcase
    end

endmodule

/* hw/rtl/isfs_checker.sv */
// ---------------------------------------------------------------------------
// isfs_checker
// Port level checks of the inverse square field sum core.
// ---------------------------------------------------------------------------
`include "inverse_square_field_sum_core_assert.svh"

module isfs_checker
    import isfs_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_stall,
    input isfs_in_t                 in_data,
    input logic                     out_valid,
    input logic                     out_stall,
    input isfs_out_t                out_data,
    input logic                     cfg_we,
    input logic [CFG_IDX_BITS-1:0]  cfg_index,
    input logic [CFG_DATA_BITS-1:0] cfg_data
);

    // a request keeps the core busy in the next cycle
    `ISFS_ASSERT_NEXT(a_busy_after_req, clk, rst_n, in_valid && !in_stall, in_stall)

    // a new result only follows a busy cycle
    `ISFS_ASSERT_NOW(a_result_after_work, clk, rst_n, $rose(out_valid), $past(in_stall))

    // stalled result stays valid
    `ISFS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)

    // stalled result keeps its value
    `ISFS_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_data))

endmodule

bind inverse_square_field_sum_core isfs_checker u_isfs_checker (.*);

/* sim/inverse_square_field_sum_core_tb.sv */
// ---------------------------------------------------------------------------
// inverse_square_field_sum_core_tb
// Drives grid points through the force field core under several source
// settings and idle patterns, and checks every end point against a
// fixed point prediction of the clamped inverse square sum.
// ---------------------------------------------------------------------------
module inverse_square_field_sum_core_tb;
    import isfs_pkg::*;

    // expected end points and the register copy they are computed from
    class field_scoreboard;
        logic [2:0]  src_count;
        logic [19:0] src_pos[MAX_SOURCES];
        logic [23:0] strength;
        logic [15:0] force_cap;
        isfs_out_t   expected_ends[$];
        int          errors;
        int          checked;

        function new();
            src_count = '0;
            foreach (src_pos[i]) src_pos[i] = '0;
            strength  = STRENGTH_RESET;
            force_cap = FORCE_CAP_RESET;
            errors    = 0;
            checked   = 0;
        endfunction

        function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned res;
            longint unsigned b;
            res = 0;
            b = 64'd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0)
            begin
                if (v >= res + b)
                begin
                    v = v - (res + b);
                    res = (res >> 1) + b;
                end
                else
                    res = res >> 1;
                b = b >> 2;
            end
            return res;
        endfunction

        function longint pull(longint unsigned mag, longint d, longint unsigned r);
            longint unsigned q;
            q = (mag * longint'(d < 0 ? -d : d) * 256) / r;
            return d < 0 ? -longint'(q) : longint'(q);
        endfunction

        function logic [19:0] clip(longint v);
            if (v > 524287) v = 524287;
            if (v < -524288) v = -524288;
            return v[19:0];
        endfunction

        function isfs_out_t field_end(isfs_in_t p);
            longint px, py, sx, sy, dx, dy, sumx, sumy;
            longint unsigned d2, mag, r;
            int n;
            isfs_out_t e;
            px = p.point_x;
            py = p.point_y;
            sumx = px * 256;
            sumy = py * 256;
            n = src_count > MAX_SOURCES ? MAX_SOURCES : src_count;
            for (int j = 0; j < n; j++)
            begin
                sx = src_pos[j][9:0];
                sy = src_pos[j][19:10];
                dx = sx - px;
                dy = sy - py;
                d2 = dx * dx + dy * dy;
                if (d2 == 0) continue;
                mag = (longint'(strength) << 8) / d2;
                if (mag > force_cap) mag = force_cap;
                r = int_sqrt(d2 << 16);
                sumx += pull(mag, dx, r);
                sumy += pull(mag, dy, r);
            end
            e.end_x = clip(sumx);
            e.end_y = clip(sumy);
            return e;
        endfunction

        function void note_request(isfs_in_t p);
            expected_ends.push_back(field_end(p));
        endfunction

        function void check_result(isfs_out_t got);
            isfs_out_t e;
            if (expected_ends.size() == 0)
            begin
                $error("unexpected result end_x=%0d end_y=%0d", got.end_x, got.end_y);
                errors++;
                return;
            end
            e = expected_ends.pop_front();
            checked++;
            if (got.end_x !== e.end_x)
            begin
                $error("end_x expected %0d actual %0d", e.end_x, got.end_x);
                errors++;
            end
            if (got.end_y !== e.end_y)
            begin
                $error("end_y expected %0d actual %0d", e.end_y, got.end_y);
                errors++;
            end
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    isfs_in_t                 in_data;
    logic                     out_valid;
    logic                     out_stall;
    isfs_out_t                out_data;
    logic                     cfg_we;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    field_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    int sent;

    inverse_square_field_sum_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    always #5 clk = ~clk;

    // result side: random stall and checking
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_data);
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // one register write, write enable left high for back-to-back writes
    task write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [23:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            REG_SOURCE_COUNT: sb.src_count = val[2:0];
            REG_STRENGTH:     sb.strength  = val;
            REG_FORCE_CAP:    sb.force_cap = val[15:0];
            default:          sb.src_pos[idx - REG_SOURCE_A] = val[19:0];
        endcase
    endtask

    // full source setting, written while the core is idle
    task load_field(input int n, input logic [19:0] s[MAX_SOURCES],
                    input logic [23:0] str, input logic [15:0] cap);
        in_valid <= 1'b0;
        while (sb.expected_ends.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        write_reg(REG_SOURCE_COUNT, 24'(n));
        for (int j = 0; j < MAX_SOURCES; j++)
            write_reg(CFG_IDX_BITS'(REG_SOURCE_A + j), 24'(s[j]));
        write_reg(REG_STRENGTH, str);
        write_reg(REG_FORCE_CAP, 24'(cap));
        cfg_we <= 1'b0;
    endtask

    // one point request
    task send_point(input int x, input int y);
        isfs_in_t p;
        p.point_x = 10'(x);
        p.point_y = 10'(y);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= p;
        do @(posedge clk); while (in_stall);
        sb.note_request(p);
        sent++;
    endtask

    function logic [19:0] pack_src(int x, int y);
        return {y[9:0], x[9:0]};
    endfunction

    // random setting with random points, some landing close to sources
    task random_phase(input int items, input bit extreme);
        logic [19:0] s[MAX_SOURCES];
        logic [23:0] str;
        logic [15:0] cap;
        int k, x, y;
        foreach (s[j]) s[j] = 20'($urandom_range(20'hFFFFF));
        str = extreme ? 24'hFFFFFF : 24'($urandom_range(24'hFFFFFF));
        cap = extreme ? 16'hFFFF : 16'($urandom_range(16'hFFFF));
        load_field(extreme ? MAX_SOURCES : $urandom_range(7), s, str, cap);
        for (int i = 0; i < items; i++)
        begin
            if ($urandom_range(3) == 0)
            begin
                k = $urandom_range(MAX_SOURCES - 1);
                x = int'(s[k][9:0]) + $urandom_range(6) - 3;
                y = int'(s[k][19:10]) + $urandom_range(6) - 3;
                send_point(x & 1023, y & 1023);
            end
            else
                send_point($urandom_range(1023), $urandom_range(1023));
        end
    endtask

    initial
    begin
        logic [19:0] s[MAX_SOURCES];
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        sent = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults: no sources
        send_point(0, 0);
        send_point(1023, 1023);

        // five sources, three of them on corner points
        s[0] = pack_src(0, 0);
        s[1] = pack_src(1023, 1023);
        s[2] = pack_src(512, 300);
        s[3] = pack_src(513, 300);
        s[4] = pack_src(0, 1023);
        load_field(5, s, 24'd1000000, 16'd5120);
        send_point(0, 0);
        send_point(1023, 1023);
        send_point(512, 300);
        send_point(1023, 0);
        send_point(511, 301);

        // excess count, zero strength, zero cap
        load_field(7, s, 24'd0, 16'hFFFF);
        send_point(100, 900);
        load_field(6, s, 24'hFFFFFF, 16'd0);
        send_point(100, 900);

        // strong pull to the right and down: end point saturates
        foreach (s[j]) s[j] = pack_src(1023, 1023);
        load_field(5, s, 24'hFFFFFF, 16'hFFFF);
        send_point(900, 900);
        send_point(1000, 1022);
        send_point(1023, 1023);

        // strong pull to the left and up
        foreach (s[j]) s[j] = pack_src(0, 0);
        load_field(5, s, 24'hFFFFFF, 16'hFFFF);
        send_point(3, 1);
        send_point(1023, 1023);

        // random part under three idle patterns
        send_idle_pct = 32;
        recv_stall_pct = 72;
        random_phase(90, 1'b0);
        random_phase(90, 1'b1);
        send_idle_pct = 72;
        recv_stall_pct = 32;
        random_phase(90, 1'b0);
        random_phase(90, 1'b0);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        random_phase(95, 1'b0);
        random_phase(95, 1'b1);
        in_valid <= 1'b0;

        while (sb.expected_ends.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        $display("sent %0d grid points across twelve source settings, checked %0d end points",
                 sent, sb.checked);
        if (sb.errors == 0)
            $display("inverse_square_field_sum_core_tb: PASS");
        else
            $display("inverse_square_field_sum_core_tb: FAIL");
        $finish;
    end

    // run limit
    initial
    begin
        #80000000;
        $display("inverse_square_field_sum_core_tb: FAIL");
        $finish;
    end

endmodule
